/* rtl/core/assert_macros.svh */
// assert_macros.svh: assertion macros shared by the checker files.
// Needs nothing else; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising clock edge, skipped while reset is low
`define UPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Check a property on each rising clock edge, reset included
`define UPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/upd_pkg.sv */
// upd_pkg: constants, the command type and the hex helper of the percent decoder.
// Used by the command interface and by the front, queue and back modules.
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Result counts of one command
    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // One classified input: up to three decoded bytes, emitted in order
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } t_cmd;

    // Hex digit check: bit 4 flags a digit, bits 3:0 carry its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Turn a plus into a space, pass all else
    function automatic logic [7:0] plain_decode(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

/* rtl/core/upd_ifs.sv */
// upd_ifs: valid/ready channels of the percent decoder (input, command, output).
// Depends on upd_pkg for the command type.
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface upd_cmd_if import upd_pkg::*; ;
    logic valid;
    logic ready;
    t_cmd cmd;

    modport source (output valid, cmd, input ready);
    modport sink   (input valid, cmd, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;

    modport source (output valid, out_byte, run_end, stream_end, input ready);
    modport sink   (input valid, out_byte, run_end, stream_end, output ready);
endinterface

/* rtl/core/upd_front.sv */
// upd_front: accepts encoded bytes, tracks the escape state and issues commands.
// Depends on upd_pkg and the channels in upd_ifs.
module upd_front import upd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upd_in_if.sink        i_in,
    upd_cmd_if.source     o_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_HELD
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_cmd       w_cmd;
    logic [4:0] w_hi, w_lo;
    logic       w_take;

    assign w_hi   = hex_value(r_held);
    assign w_lo   = hex_value(i_in.in_byte);
    assign w_take = i_in.valid && i_in.ready;

    // Classify the byte against the escape state
    always_comb begin
        n_phase    = PH_IDLE;
        n_held     = r_held;
        w_cmd      = '0;
        w_cmd.last = i_in.in_last;
        case (r_phase)
            PH_PCT: begin
                if (i_in.in_last) begin
                    w_cmd.count = CNT_TWO;
                    w_cmd.b0    = CH_PERCENT;
                    w_cmd.b1    = plain_decode(i_in.in_byte);
                end else begin
                    n_held  = i_in.in_byte;
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                if (w_hi[4] && w_lo[4]) begin
                    w_cmd.count = CNT_ONE;
                    w_cmd.b0    = {w_hi[3:0], w_lo[3:0]};
                end else begin
                    w_cmd.count = CNT_THREE;
                    w_cmd.b0    = CH_PERCENT;
                    w_cmd.b1    = r_held;
                    w_cmd.b2    = i_in.in_byte;
                end
            end
            default: begin
                if (i_in.in_byte == CH_PERCENT && !i_in.in_last) begin
                    n_phase = PH_PCT;
                end else begin
                    w_cmd.count = CNT_ONE;
                    w_cmd.b0    = plain_decode(i_in.in_byte);
                end
            end
        endcase
    end

    // Push only bytes that cause results; hold off when the queue is full
    assign i_in.ready  = o_cmd.ready;
    assign o_cmd.valid = i_in.valid && (w_cmd.count != CNT_NONE);
    assign o_cmd.cmd   = w_cmd;

    // Advance the escape state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

/* rtl/core/upd_queue.sv */
// upd_queue: small FIFO of commands between the front and the back.
// Depends on upd_pkg and the channels in upd_ifs.
module upd_queue import upd_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upd_cmd_if.sink     i_cmd,
    upd_cmd_if.source   o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign i_cmd.ready = (r_count != CW'(DEPTH));
    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_slot[r_rd_ptr];
    assign w_push      = i_cmd.valid && i_cmd.ready;
    assign w_pop       = o_cmd.valid && o_cmd.ready;

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd.cmd;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/upd_back.sv */
// upd_back: takes commands and emits their decoded bytes one per cycle while the sink is ready.
// Depends on upd_pkg and the channels in upd_ifs.
module upd_back import upd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upd_cmd_if.sink     i_cmd,
    upd_out_if.source   o_out
);

    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_final, w_take, w_fire;

    assign w_final = (r_idx == r_cmd.count - 2'd1);
    assign w_fire  = o_out.valid && o_out.ready;
    // Take the next command as the final byte of the current one leaves
    assign i_cmd.ready = !r_busy || (o_out.ready && w_final);
    assign w_take      = i_cmd.valid && i_cmd.ready;

    // Select the byte under the index
    always_comb begin
        case (r_idx)
            2'd0:    o_out.out_byte = r_cmd.b0;
            2'd1:    o_out.out_byte = r_cmd.b1;
            default: o_out.out_byte = r_cmd.b2;
        endcase
    end

    assign o_out.valid      = r_busy;
    assign o_out.run_end    = w_final;
    assign o_out.stream_end = w_final && r_cmd.last;

    // Load the command payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= i_cmd.cmd;
        end
    end

    // Step through the bytes of the held command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_fire) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

/* rtl/core/url_percent_decoder.sv */
// url_percent_decoder: streaming URL percent decoder, top level.
// Depends on upd_pkg, upd_ifs, upd_front, upd_queue and upd_back.
//
// The block takes one encoded byte per cycle on i_in and gives decoded bytes on
// o_out. A plus becomes a space, a percent with two hex digits becomes the byte
// they name, and a percent with anything else passes through with its two
// characters unchanged; a percent too near the end of the stream is passed on
// literally. Each input byte causes zero to three results; run_end marks the
// last result of a byte and stream_end the last result of the stream. The
// front classifies a byte in the cycle it is accepted, a queue of DEPTH
// commands follows, and the back's output register sends one result per
// cycle while the sink is ready; a result passes through the queue and that
// register. Input runs at one byte per cycle as long as the bytes average at
// most one result each; a byte that causes three results holds the output
// until all three have left, and the input stalls once the queue is full.
module url_percent_decoder #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upd_in_if.sink      i_in,
    upd_out_if.source   o_out
);

    upd_cmd_if w_front_cmd ();
    upd_cmd_if w_back_cmd ();

    // Classify incoming bytes
    upd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (w_front_cmd.source)
    );

    // Decouple the two sides
    upd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_front_cmd.sink),
        .o_cmd   (w_back_cmd.source)
    );

    // Emit decoded bytes
    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_back_cmd.sink),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/upd_checker.sv */
// upd_checker: port-level assertions on the percent decoder, bound to its top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module upd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_end,
    input  logic       i_stream_end
);

    // A result waiting for the sink holds its payload
    `UPD_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_run_end) && $stable(i_stream_end), "stalled result changed")

    // The end of a stream always closes the run of its byte
    `UPD_ASSERT(a_stream_run, i_clk, i_rst_n, i_out_valid && i_stream_end |-> i_run_end, "stream_end without run_end")

    // The results of one byte leave without a gap
    `UPD_ASSERT(a_run_gapless, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_run_end |=> i_out_valid, "gap inside a run of results")

    // Reset empties the output
    `UPD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result shown after reset")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_run_end    (o_out.run_end),
    .i_stream_end (o_out.stream_end)
);

/* verif/url_percent_decoder_tb.sv */
`timescale 1ns / 100ps
// url_percent_decoder_tb: self-checking testbench of the streaming URL percent decoder.
// Depends on upd_pkg, upd_ifs and the url_percent_decoder RTL; drives random and
// directed encoded streams and checks every decoded item against its own decoder model.
module url_percent_decoder_tb;
    import upd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 310;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // Escape tracking of the decoder model
    typedef enum logic [1:0] {
        ESC_IDLE    = 2'd0,
        ESC_PERCENT = 2'd1,
        ESC_HELD    = 2'd2
    } esc_state_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        SINK_OPEN    = 2'd0,
        SINK_COIN    = 2'd1,
        SINK_SPARSE  = 2'd2,
        SINK_BURSTY  = 2'd3
    } sink_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } dec_result_t;

    logic i_clk;
    logic i_rst_n;

    upd_in_if  enc_ch ();
    upd_out_if dec_ch ();

    url_percent_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (enc_ch),
        .o_out   (dec_ch)
    );

    // Decoder model state and the decoded bytes still owed by the block
    esc_state_t  esc_state;
    logic [7:0]  held_byte;
    dec_result_t decoded_q[$];
    dec_result_t seen_result;

    int mismatch_count;
    int cycle_count;
    int burst_left;
    int sent_count;

    // Clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Hex digit test and value, high digit or low digit alike
    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - "a" + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // Advance the decoder model by one accepted item and queue what it owes
    function automatic void decode_byte(input logic [7:0] c, input logic last);
        logic [7:0]  bytes [3];
        int          n;
        logic [3:0]  hi;
        logic [3:0]  lo;
        bit          hi_ok;
        bit          lo_ok;
        dec_result_t r;
        n = 0;
        case (esc_state)
            ESC_PERCENT: begin
                if (last) begin
                    bytes[0] = CH_PERCENT;
                    bytes[1] = plus_to_space(c);
                    n = 2;
                    esc_state = ESC_IDLE;
                end else begin
                    held_byte = c;
                    esc_state = ESC_HELD;
                end
            end
            ESC_HELD: begin
                hi_ok = hex_nibble(held_byte, hi);
                lo_ok = hex_nibble(c, lo);
                if (hi_ok && lo_ok) begin
                    bytes[0] = {hi, lo};
                    n = 1;
                end else begin
                    // Broken escape: pass all three characters untouched
                    bytes[0] = CH_PERCENT;
                    bytes[1] = held_byte;
                    bytes[2] = c;
                    n = 3;
                end
                esc_state = ESC_IDLE;
            end
            default: begin
                esc_state = ESC_IDLE;
                if (c == CH_PERCENT && !last) begin
                    esc_state = ESC_PERCENT;
                end else begin
                    bytes[0] = plus_to_space(c);
                    n = 1;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            r.data       = bytes[k];
            r.run_end    = (k == n - 1);
            r.stream_end = (k == n - 1) && last;
            decoded_q.push_back(r);
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endfunction

    // Compare one output item with the oldest owed byte
    function automatic void check_result(input dec_result_t got);
        dec_result_t want;
        if (decoded_q.size() == 0) begin
            note_failure($sformatf("unexpected item byte=%h run_end=%b stream_end=%b",
                                   got.data, got.run_end, got.stream_end));
            return;
        end
        want = decoded_q.pop_front();
        if (got.data !== want.data || got.run_end !== want.run_end ||
            got.stream_end !== want.stream_end) begin
            note_failure($sformatf(
                "expected byte=%h run_end=%b stream_end=%b, got byte=%h run_end=%b stream_end=%b",
                want.data, want.run_end, want.stream_end,
                got.data, got.run_end, got.stream_end));
        end
    endfunction

    // Predict on each accepted input item, then check each accepted output item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (enc_ch.valid === 1'b1 && enc_ch.ready === 1'b1) begin
                decode_byte(enc_ch.in_byte, enc_ch.in_last);
            end
            if (dec_ch.valid === 1'b1 && dec_ch.ready === 1'b1) begin
                seen_result.data       = dec_ch.out_byte;
                seen_result.run_end    = dec_ch.run_end;
                seen_result.stream_end = dec_ch.stream_end;
                check_result(seen_result);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("url_percent_decoder verification failed");
            $finish;
        end
    end

    // Receiver: stall the output in patterns that change at random
    initial begin : sink_stalls
        sink_mode_t mode;
        int         tick;
        int         hold_left;
        dec_ch.ready = 1'b0;
        mode = SINK_OPEN;
        tick = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 48 == 0) begin
                mode = sink_mode_t'($urandom_range(0, 3));
            end
            case (mode)
                SINK_OPEN:   dec_ch.ready <= 1'b1;
                SINK_COIN:   dec_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: dec_ch.ready <= (tick % 4 == 0);
                default: begin
                    if (hold_left == 0) begin
                        dec_ch.ready <= ~dec_ch.ready;
                        hold_left = $urandom_range(1, 8);
                    end
                    hold_left--;
                end
            endcase
        end
    end

    // Send one item in bursts with random gaps; call at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                enc_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        enc_ch.valid   <= 1'b1;
        enc_ch.in_byte <= b;
        enc_ch.in_last <= last;
        do @(posedge i_clk); while (enc_ch.ready !== 1'b1);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], k == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'("0" + r);
        if (r < 16) return 8'("A" + r - 10);
        return 8'("a" + r - 16);
    endfunction

    // Pick a non-hex character, often one just outside a digit range
    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        logic [3:0] v;
        case ($urandom_range(0, 7))
            0: c = 8'h2F;
            1: c = 8'h3A;
            2: c = 8'h40;
            3: c = 8'h47;
            4: c = 8'h60;
            5: c = 8'h67;
            default: begin
                c = 8'($urandom_range(0, 255));
                if (hex_nibble(c, v)) c = c ^ 8'h80;
            end
        endcase
        return c;
    endfunction

    // Plain bytes at the extremes, a plus, and a mark on a plain byte
    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_PLUS, 1'b0);
        send_byte("a", 1'b1);
    endtask

    // Good escapes at the digit extremes, broken escapes, a plus held in an escape
    task automatic test_escapes();
        send_text("%09");
        send_text("%Af");
        send_text("%fF");
        send_text("%4g");
        send_text("%+7");
    endtask

    // Percent as the final character, then percent with one final character
    task automatic test_cut_short();
        send_byte(CH_PERCENT, 1'b1);
        send_byte(CH_PERCENT, 1'b0);
        send_byte(CH_PLUS, 1'b1);
    endtask

    // Mostly well-formed streams with random content, some noise and cut-off tails
    task automatic test_random_streams();
        logic [7:0] stream_q[$];
        int         tokens;
        int         keep;
        while (sent_count < RANDOM_ITEMS) begin
            stream_q.delete();
            tokens = $urandom_range(1, 8);
            repeat (tokens) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: stream_q.push_back(8'($urandom_range(0, 255)));
                    3:       stream_q.push_back(CH_PLUS);
                    4, 5, 6: begin
                        stream_q.push_back(CH_PERCENT);
                        stream_q.push_back(random_hex_char());
                        stream_q.push_back(random_hex_char());
                    end
                    7, 8: begin
                        stream_q.push_back(CH_PERCENT);
                        case ($urandom_range(0, 2))
                            0: begin
                                stream_q.push_back(random_bad_char());
                                stream_q.push_back(random_hex_char());
                            end
                            1: begin
                                stream_q.push_back(random_hex_char());
                                stream_q.push_back(random_bad_char());
                            end
                            default: begin
                                stream_q.push_back(random_bad_char());
                                stream_q.push_back(8'($urandom_range(0, 255)));
                            end
                        endcase
                    end
                    default: stream_q.push_back(CH_PERCENT);
                endcase
            end
            // Cut the tail now and then so escapes end early
            if ($urandom_range(0, 3) == 0 && stream_q.size() > 1) begin
                keep = $urandom_range(1, stream_q.size() - 1);
                while (stream_q.size() > keep) void'(stream_q.pop_back());
            end
            foreach (stream_q[k]) begin
                send_byte(stream_q[k], k == stream_q.size() - 1);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        enc_ch.valid   = 1'b0;
        enc_ch.in_byte = 8'h00;
        enc_ch.in_last = 1'b0;
        esc_state      = ESC_IDLE;
        held_byte      = 8'h00;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        sent_count     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_plain_bytes();
        test_escapes();
        test_cut_short();
        sent_count = 0;
        test_random_streams();
        enc_ch.valid <= 1'b0;

        // Drain the owed bytes, then watch for strays
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            note_failure($sformatf("%0d decoded bytes never arrived", decoded_q.size()));
        end

        if (mismatch_count == 0) begin
            $display("url_percent_decoder verification clean");
        end else begin
            $display("url_percent_decoder verification failed");
        end
        $finish;
    end

endmodule
